// ===== hw/rtl/pol_pkg.sv =====
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants of the positional ordered list
// Store sizing, field widths, request and status codes, result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

	// store sizing
	localparam int CAPACITY = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// beat field widths
	localparam int MODE_W   = 2;
	localparam int POS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 6;

	// width for position against count compares
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// request codes
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

	// one result beat
	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [VAL_W-1:0]  value_out;
		logic [COUNT_W-1:0]       count;
	} pol_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pol_if.sv =====
// ----------------------------------------------------------------------------
// pol_if: request and response channels of the positional ordered list
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pol_req_if;
	import pol_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value_in;

	modport source (output valid, output mode, output position, output value_in,
		input ready);
	modport sink (input valid, input mode, input position, input value_in,
		output ready);
endinterface

interface pol_rsp_if;
	import pol_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] value_out;
	logic [COUNT_W-1:0]      count;

	modport source (output valid, output status, output value_out, output count,
		input ready);
	modport sink (input valid, input status, input value_out, input count,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pol_ram.sv =====
// ----------------------------------------------------------------------------
// pol_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pol_ctrl.sv =====
// ----------------------------------------------------------------------------
// pol_ctrl: request sequencer of the positional ordered list
// Checks each request, then walks the store one entry per cycle through a
// single address stepper, moving words up or down and reading the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pol_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pol_req_if.sink                            req,
	output      pol_pkg::pol_res_t             res,
	output      logic                          res_valid,
	input  wire logic                          res_ready,
	output      logic                          ram_we,
	output      logic [pol_pkg::ADDR_W-1:0]    ram_waddr,
	output      logic [pol_pkg::VAL_W-1:0]     ram_wdata,
	output      logic [pol_pkg::ADDR_W-1:0]    ram_raddr,
	input  wire logic [pol_pkg::VAL_W-1:0]     ram_rdata
);
	import pol_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		SHIFT,
		DRAIN,
		WRVAL,
		DONE
	} state_t;

	state_t                  state_q;
	logic [MODE_W-1:0]       op_q;
	logic [VAL_W-1:0]        val_q;
	logic [ADDR_W-1:0]       rd_ptr_q;
	logic [ADDR_W-1:0]       last_q;
	logic                    first_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [STAT_W-1:0]       status_q;
	logic [VAL_W-1:0]        value_q;

	logic                    rd_vld_s1;
	logic                    rd_first_s1;
	logic [ADDR_W-1:0]       rd_addr_s1;

	logic [CMP_W-1:0]        pos_c;
	logic [CMP_W-1:0]        cnt_c;
	logic                    pos_nz;
	logic                    in_list;
	logic                    full;
	logic [ADDR_W-1:0]       pos_m1;
	logic [ADDR_W-1:0]       cnt_m1;

	// request checks against the current count
	always_comb begin
		pos_c   = CMP_W'(req.position);
		cnt_c   = CMP_W'(cnt_q);
		pos_nz  = (pos_c != '0);
		in_list = pos_nz && (pos_c <= cnt_c);
		full    = (cnt_q == CNT_W'(CAPACITY));
		pos_m1  = ADDR_W'(req.position - POS_W'(1));
		cnt_m1  = ADDR_W'(cnt_q - CNT_W'(1));
	end

	assign req.ready = (state_q == IDLE);

	// store write port: moved word during the walk, new word at the end
	always_comb begin
		ram_we    = (rd_vld_s1 && ((op_q == MODE_INSERT) || !rd_first_s1)) ||
			(state_q == WRVAL);
		ram_raddr = rd_ptr_q;
		if (state_q == WRVAL) begin
			ram_waddr = last_q;
			ram_wdata = val_q;
		end else if (op_q == MODE_INSERT) begin
			ram_waddr = rd_addr_s1 + ADDR_W'(1);
			ram_wdata = ram_rdata;
		end else begin
			ram_waddr = rd_addr_s1 - ADDR_W'(1);
			ram_wdata = ram_rdata;
		end
	end

	// result beat towards the output register
	assign res_valid     = (state_q == DONE);
	assign res.status    = status_q;
	assign res.value_out = value_q;
	assign res.count     = COUNT_W'(cnt_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;

			// first word back on read and delete is the result
			if (rd_vld_s1 && rd_first_s1 && (op_q != MODE_INSERT)) begin
				value_q <= ram_rdata;
			end

			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						op_q     <= req.mode;
						val_q    <= req.value_in;
						value_q  <= '0;
						status_q <= ST_BADPOS;
						first_q  <= 1'b1;
						state_q  <= DONE;
						case (req.mode)
							MODE_READ: begin
								if (in_list) begin
									status_q <= ST_OK;
									rd_ptr_q <= pos_m1;
									last_q   <= pos_m1;
									state_q  <= SHIFT;
								end
							end
							MODE_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (pos_nz && (pos_c <= cnt_c + CMP_W'(1))) begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q + CNT_W'(1);
									last_q   <= pos_m1;
									rd_ptr_q <= cnt_m1;
									// append needs no move
									state_q  <= (pos_c <= cnt_c) ? SHIFT : WRVAL;
								end
							end
							MODE_DELETE: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
								end else if (in_list) begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q - CNT_W'(1);
									rd_ptr_q <= pos_m1;
									last_q   <= cnt_m1;
									state_q  <= SHIFT;
								end
							end
							default: begin
								status_q <= ST_BADPOS;
							end
						endcase
					end
				end
				SHIFT: begin
					rd_vld_s1   <= 1'b1;
					rd_addr_s1  <= rd_ptr_q;
					rd_first_s1 <= first_q;
					first_q     <= 1'b0;
					if (rd_ptr_q == last_q) begin
						state_q <= DRAIN;
					end else if (op_q == MODE_INSERT) begin
						rd_ptr_q <= rd_ptr_q - ADDR_W'(1);
					end else begin
						rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
					end
				end
				DRAIN: begin
					state_q <= (op_q == MODE_INSERT) ? WRVAL : DONE;
				end
				WRVAL: begin
					state_q <= DONE;
				end
				DONE: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// count stays within the store
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// store is written only while a request is being worked
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == SHIFT || state_q == DRAIN || state_q == WRVAL))
		else $error("store write outside a request");

	// read data returns only right after a walk step
	a_rd_return: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == SHIFT)
		else $error("read return without a walk step");

	// a moved word never lands on the entry being read
	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == SHIFT) |-> (ram_waddr != ram_raddr))
		else $error("store write and read collide during the walk");

endmodule

`default_nettype wire

// ===== hw/rtl/positional_ordered_list.sv =====
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list of signed 32-bit words
// Read, insert or delete at a 1-based position; insert and delete move the
// later words one place through a walk of the store.
//
//   beat   dir  handshake     payload
//   req    in   valid/ready   mode, position, value_in
//   rsp    out  valid/ready   status, value_out, count
//
// A rejected request goes straight to the result; a read walks its one entry,
// a delete walks from the position up to the last word, an insert walks from
// the last word down to the position and then writes the new word, and an
// append only writes the new word. The walk moves one store word per cycle
// through the one read and one write port of the store.
// Reset clears the count and control only; store words are written before
// they are ever read. A stalled rsp holds its beat while the next request
// is accepted and worked.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list (
	input  wire logic clk,
	input  wire logic arst_n,
	pol_req_if.sink   req,
	pol_rsp_if.source rsp
);
	import pol_pkg::*;

	pol_res_t           res;
	logic               res_valid;
	logic               res_ready;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [VAL_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [VAL_W-1:0]   ram_rdata;

	logic               out_valid_q;
	pol_res_t           out_q;

	pol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	pol_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register takes a result when empty or being drained
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_q.status;
	assign rsp.value_out = out_q.value_out;
	assign rsp.count     = out_q.count;

endmodule

`default_nettype wire
